/* src/tws_pkg.sv */
// Package: shared widths, constants and lane result type for the window statistics core.
package tws_pkg;

  localparam int unsigned MaxAxes       = 3;
  localparam int unsigned SampleW       = 16;
  localparam int unsigned SumW          = 33;
  localparam int unsigned SqSumW        = 47;
  localparam int unsigned CountW        = 16;
  localparam int unsigned VarW          = 31;
  localparam int unsigned StdW          = 16;
  localparam logic [CountW-1:0] WindowReset = 16'd6000;

  typedef struct packed {
    logic signed [SampleW-1:0] mean;
    logic [VarW-1:0]           variance;
    logic [StdW-1:0]           std_dev;
    logic signed [SampleW-1:0] min_val;
    logic signed [SampleW-1:0] max_val;
  } lane_result_t;

endpackage

/* src/triaxial_window_statistics_core.sv */
// Top level: triaxial windowed mean, variance, std, min and max with per-axis lanes.
//
// channel | direction | handshake         | contents
// in      | in        | in_valid/in_stall | axis_x/y/z, restart
// out     | out       | out_valid/out_stall | one result per axis
// cfg     | in        | cfg_valid/cfg_ready | window_length
//
// A sample is taken while the window is open. The lanes start in the cycle
// after the transaction that closes a window and run through two
// 47-step divides, one multiply, one subtract, a 16-step square root and a
// result load. Then AXES results leave in order, one per cycle unless stalled.
// Input stalls from window close until the last result is taken.
// Reset: window_length 6000, all accumulators clear.
module triaxial_window_statistics_core #(
  parameter int unsigned AXES = tws_pkg::MaxAxes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  input  logic        restart_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  axis_index_o,
  output logic signed [15:0] mean_value_o,
  output logic [30:0] variance_value_o,
  output logic [15:0] std_value_o,
  output logic signed [15:0] min_value_o,
  output logic signed [15:0] max_value_o,
  output logic [15:0] sample_count_o,
  output logic        last_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [1:0] {StAcc, StCalc, StEmit} state_e;

  state_e state_q;
  logic [15:0] wlen_q, cnt_q, n_q;
  logic [1:0]  idx_q;
  logic        start_q;
  logic        acc, win_close;
  logic [15:0] cnt_d, cnt_base;
  logic signed [15:0] samples [tws_pkg::MaxAxes];
  logic [AXES-1:0] done;
  tws_pkg::lane_result_t res [AXES];

  assign samples[0] = axis_x_i;
  assign samples[1] = axis_y_i;
  assign samples[2] = axis_z_i;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_q != StAcc);
  assign acc       = in_valid && !in_stall;
  assign cnt_base  = restart_i ? '0 : cnt_q;
  assign cnt_d     = cnt_base + 16'd1;
  assign win_close = (cnt_d >= wlen_q) || (cnt_d == '0);

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    tws_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .acc_i    (acc),
      .clear_i  (restart_i),
      .first_i  (cnt_base == '0),
      .sample_i (samples[a]),
      .start_i  (start_q),
      .count_i  (n_q),
      .done_o   (done[a]),
      .result_o (res[a])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StAcc;
      wlen_q  <= tws_pkg::WindowReset;
      cnt_q   <= '0;
      n_q     <= '0;
      idx_q   <= '0;
      start_q <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) wlen_q <= cfg_data_i;
      start_q <= acc && win_close;
      case (state_q)
        StAcc: begin
          if (acc) begin
            if (win_close) begin
              n_q     <= (cnt_d == '0) ? 16'd1 : cnt_d;
              cnt_q   <= '0;
              idx_q   <= '0;
              state_q <= StCalc;
            end else begin
              cnt_q <= cnt_d;
            end
          end
        end
        StCalc: if (&done) state_q <= StEmit;
        StEmit: begin
          if (!out_stall) begin
            if (32'(idx_q) == AXES - 1) state_q <= StAcc;
            else idx_q <= idx_q + 2'd1;
          end
        end
        default: state_q <= StAcc;
      endcase
    end
  end

  tws_pkg::lane_result_t sel;
  always_comb begin
    sel = res[0];
    for (int a = 0; a < AXES; a++) if (32'(idx_q) == a) sel = res[a];
  end

  assign out_valid        = (state_q == StEmit);
  assign axis_index_o     = idx_q;
  assign mean_value_o     = sel.mean;
  assign variance_value_o = sel.variance;
  assign std_value_o      = sel.std_dev;
  assign min_value_o      = sel.min_val;
  assign max_value_o      = sel.max_val;
  assign sample_count_o   = n_q;
  assign last_o           = (32'(idx_q) == AXES - 1);

endmodule

/* src/tws_lane.sv */
// One axis lane: window accumulators plus serial divide and square-root for the statistics.
module tws_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 acc_i,
  input  logic                                 clear_i,
  input  logic                                 first_i,
  input  logic signed [tws_pkg::SampleW-1:0]   sample_i,
  input  logic                                 start_i,
  input  logic [tws_pkg::CountW-1:0]           count_i,
  output logic                                 done_o,
  output tws_pkg::lane_result_t                result_o
);

  typedef enum logic [2:0] {
    StIdle, StDivSum, StDivSq, StMul, StVar, StSqrt, StDone
  } state_e;

  localparam int unsigned DivW = tws_pkg::SqSumW;

  state_e state_q;
  logic signed [tws_pkg::SumW-1:0]   sum_q;
  logic [tws_pkg::SqSumW-1:0]        sqsum_q;
  logic signed [tws_pkg::SampleW-1:0] min_q, max_q;

  logic [DivW-1:0]                  dividend_q;
  logic [tws_pkg::CountW:0]         rem_q;
  logic [5:0]                       bit_q;
  logic                             neg_q;
  logic signed [tws_pkg::SampleW-1:0] mean_q;
  logic [31:0]                      msq_q;
  logic [DivW-1:0]                  quot_q;
  logic [31:0]                      rad_q, root_q, sbit_q;
  logic [tws_pkg::VarW-1:0]         var_q;

  logic signed [tws_pkg::SumW-1:0]  sum_d;
  logic [31:0]                      sq_d;
  logic [tws_pkg::CountW+1:0]       shifted;
  logic [DivW-1:0]                  sum_abs;
  logic [32:0]                      rb;

  assign sq_d    = 32'($signed(sample_i) * $signed(sample_i));
  assign shifted = {rem_q, dividend_q[DivW-1]};
  assign sum_abs = sum_q[tws_pkg::SumW-1] ? DivW'(-sum_q) : DivW'(sum_q);
  assign rb      = 33'(root_q) + 33'(sbit_q);

  always_comb begin
    sum_d = clear_i ? '0 : sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sum_q   <= '0;
      sqsum_q <= '0;
      min_q   <= '0;
      max_q   <= '0;
    end else begin
      if (acc_i) begin
        sum_q   <= sum_d + tws_pkg::SumW'(sample_i);
        sqsum_q <= (clear_i ? '0 : sqsum_q) + tws_pkg::SqSumW'(sq_d);
        if (first_i || sample_i < min_q) min_q <= sample_i;
        if (first_i || sample_i > max_q) max_q <= sample_i;
      end
      case (state_q)
        StIdle: begin
          if (start_i) begin
            dividend_q <= sum_abs;
            neg_q      <= sum_q[tws_pkg::SumW-1];
            rem_q      <= '0;
            bit_q      <= 6'(DivW - 1);
            result_o.min_val <= min_q;
            result_o.max_val <= max_q;
            sum_q   <= '0;
            state_q <= StDivSum;
          end
        end
        StDivSum, StDivSq: begin
          if (shifted >= {1'b0, count_i}) begin
            rem_q      <= (tws_pkg::CountW+1)'(shifted - {1'b0, count_i});
            dividend_q <= {dividend_q[DivW-2:0], 1'b1};
          end else begin
            rem_q      <= shifted[tws_pkg::CountW:0];
            dividend_q <= {dividend_q[DivW-2:0], 1'b0};
          end
          if (bit_q != '0) begin
            bit_q <= bit_q - 6'd1;
          end else if (state_q == StDivSum) begin
            mean_q <= neg_q ? -tws_pkg::SampleW'(dividend_q[tws_pkg::SampleW-2:0] << 1
                                                  | tws_pkg::SampleW'(shifted >= {1'b0, count_i}))
                            : tws_pkg::SampleW'({dividend_q[DivW-2:0],
                                                 shifted >= {1'b0, count_i}});
            dividend_q <= sqsum_q;
            sqsum_q    <= '0;
            rem_q      <= '0;
            bit_q      <= 6'(DivW - 1);
            state_q    <= StDivSq;
          end else begin
            quot_q  <= {dividend_q[DivW-2:0], shifted >= {1'b0, count_i}};
            state_q <= StMul;
          end
        end
        StMul: begin
          msq_q   <= 32'($signed(mean_q) * $signed(mean_q));
          state_q <= StVar;
        end
        StVar: begin
          if (quot_q >= DivW'(msq_q)) begin
            if (quot_q - DivW'(msq_q) > DivW'(32'h7FFF_FFFF)) var_q <= '1;
            else var_q <= tws_pkg::VarW'(quot_q - DivW'(msq_q));
          end else begin
            var_q <= '0;
          end
          rad_q   <= '0;
          root_q  <= '0;
          sbit_q  <= 32'h4000_0000;
          state_q <= StSqrt;
        end
        StSqrt: begin
          if (sbit_q == 32'h4000_0000) rad_q <= 32'(var_q);
          if ((sbit_q == 32'h4000_0000 ? 33'(var_q) : 33'(rad_q)) >= rb) begin
            rad_q  <= 32'((sbit_q == 32'h4000_0000 ? 33'(var_q) : 33'(rad_q)) - rb);
            root_q <= (root_q >> 1) + sbit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
          if (sbit_q == 32'd1) state_q <= StDone;
        end
        StDone: begin
          result_o.mean     <= mean_q;
          result_o.variance <= var_q;
          result_o.std_dev  <= tws_pkg::StdW'(root_q);
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign done_o = (state_q == StDone);

endmodule

/* tb/tws_checker.sv */
// Checker: watches all channels, predicts window statistics and compares results.
module tws_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  input  logic        restart_i,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  axis_index_o,
  input  logic signed [15:0] mean_value_o,
  input  logic [30:0] variance_value_o,
  input  logic [15:0] std_value_o,
  input  logic signed [15:0] min_value_o,
  input  logic signed [15:0] max_value_o,
  input  logic [15:0] sample_count_o,
  input  logic        last_o,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatch_count_o,
  output int          pending_stats_o,
  output int          stats_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         axis;
    logic signed [15:0] mean;
    logic [30:0]        variance;
    logic [15:0]        std_dev;
    logic signed [15:0] min_val;
    logic signed [15:0] max_val;
    logic [15:0]        count;
    logic               last;
  } axis_stats_t;

  axis_stats_t stats_q[$];

  logic [15:0]    window_len;
  longint         sum_acc[3];
  longint         sq_acc[3];
  logic signed [15:0] min_acc[3];
  logic signed [15:0] max_acc[3];
  logic [15:0]    count_acc;

  assign pending_stats_o = stats_q.size();

  function automatic logic [15:0] floor_sqrt(longint v);
    longint root;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      if ((root | (64'sd1 << b)) * (root | (64'sd1 << b)) <= v) root = root | (64'sd1 << b);
    end
    return root[15:0];
  endfunction

  task automatic clear_window();
    for (int a = 0; a < 3; a++) begin
      sum_acc[a] = 0;
      sq_acc[a] = 0;
      min_acc[a] = '0;
      max_acc[a] = '0;
    end
    count_acc = '0;
  endtask

  task automatic take_sample(logic signed [15:0] xs, logic signed [15:0] ys,
                             logic signed [15:0] zs, logic rst_win);
    logic signed [15:0] smp[3];
    longint n, mean, msq, q, var_l;
    axis_stats_t st;
    smp[0] = xs;
    smp[1] = ys;
    smp[2] = zs;
    if (rst_win) clear_window();
    for (int a = 0; a < 3; a++) begin
      sum_acc[a] += longint'(smp[a]);
      sq_acc[a] += longint'(smp[a]) * longint'(smp[a]);
      if (count_acc == 0) begin
        min_acc[a] = smp[a];
        max_acc[a] = smp[a];
      end else begin
        if (smp[a] < min_acc[a]) min_acc[a] = smp[a];
        if (smp[a] > max_acc[a]) max_acc[a] = smp[a];
      end
    end
    count_acc = count_acc + 16'd1;
    if (count_acc < window_len && count_acc != 0) return;
    n = (count_acc == 0) ? 1 : longint'(count_acc);
    for (int a = 0; a < 3; a++) begin
      mean = sum_acc[a] / n;
      msq = mean * mean;
      q = sq_acc[a] / n;
      var_l = (q >= msq) ? q - msq : 0;
      if (var_l > 64'h7FFF_FFFF) var_l = 64'h7FFF_FFFF;
      st.axis = a[1:0];
      st.mean = mean[15:0];
      st.variance = var_l[30:0];
      st.std_dev = floor_sqrt(var_l);
      st.min_val = min_acc[a];
      st.max_val = max_acc[a];
      st.count = n[15:0];
      st.last = (a == 2);
      stats_q.push_back(st);
    end
    clear_window();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    axis_stats_t exp_st;
    if (!rst_ni) begin
      window_len = 16'd6000;
      clear_window();
      stats_q.delete();
      mismatch_count_o = 0;
      stats_seen_o = 0;
    end else begin
      if (cfg_valid && cfg_ready) window_len = cfg_data;
      if (in_valid && !in_stall) take_sample(axis_x_i, axis_y_i, axis_z_i, restart_i);
      if (out_valid && !out_stall) begin
        stats_seen_o++;
        if (stats_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("ERROR: unexpected result transaction, axis %0d", axis_index_o);
        end else begin
          exp_st = stats_q.pop_front();
          if (exp_st.axis !== axis_index_o || exp_st.mean !== mean_value_o ||
              exp_st.variance !== variance_value_o || exp_st.std_dev !== std_value_o ||
              exp_st.min_val !== min_value_o || exp_st.max_val !== max_value_o ||
              exp_st.count !== sample_count_o || exp_st.last !== last_o) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("ERROR: exp axis %0d mean %0d var %0d std %0d min %0d max %0d n %0d last %0d",
                       exp_st.axis, exp_st.mean, exp_st.variance, exp_st.std_dev,
                       exp_st.min_val, exp_st.max_val, exp_st.count, exp_st.last);
              $display("       got axis %0d mean %0d var %0d std %0d min %0d max %0d n %0d last %0d",
                       axis_index_o, mean_value_o, variance_value_o, std_value_o,
                       min_value_o, max_value_o, sample_count_o, last_o);
            end
          end
        end
      end
    end
  end
endmodule

/* tb/tb_top.sv */
// Testbench top: stimulus, idling phases and verdict for the window statistics core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] ax = '0, ay = '0, az = '0;
  logic restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] axis_index;
  logic signed [15:0] mean_value, min_value, max_value;
  logic [30:0] variance_value;
  logic [15:0] std_value, sample_count;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  int mismatches, pending, stats_seen;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  bit hold_req_d = 0;
  int quiet_cycles = 0;
  int samples_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triaxial_window_statistics_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .axis_x_i(ax), .axis_y_i(ay), .axis_z_i(az), .restart_i(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .axis_index_o(axis_index), .mean_value_o(mean_value),
    .variance_value_o(variance_value), .std_value_o(std_value),
    .min_value_o(min_value), .max_value_o(max_value),
    .sample_count_o(sample_count), .last_o(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data_i(cfg_data)
  );

  tws_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .axis_x_i(ax), .axis_y_i(ay), .axis_z_i(az), .restart_i(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .axis_index_o(axis_index), .mean_value_o(mean_value),
    .variance_value_o(variance_value), .std_value_o(std_value),
    .min_value_o(min_value), .max_value_o(max_value),
    .sample_count_o(sample_count), .last_o(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatch_count_o(mismatches), .pending_stats_o(pending), .stats_seen_o(stats_seen)
  );

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    hold_req_d <= hold_req;
    if (hold_req && !hold_req_d) begin
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_sample(logic signed [15:0] xs, logic signed [15:0] ys,
                             logic signed [15:0] zs, logic rst_win);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ax <= xs;
    ay <= ys;
    az <= zs;
    restart <= rst_win;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_window(logic [15:0] len);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic random_phase(int items, int s_pct, int r_pct, bit with_hold);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 20 == 0) write_window(16'($urandom_range(1, 8)));
      if (with_hold && i == 20) hold_req = 1;
      send_sample(rand_axis(), rand_axis(), rand_axis(), $urandom_range(19) == 0);
    end
    hold_req = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // default window length: nothing closes
    send_sample(16'sd100, -16'sd100, 16'sd0, 1'b0);
    send_sample(16'sd7, 16'sd7, 16'sd7, 1'b0);
    send_sample(-16'sd5, 16'sd3, 16'sd1, 1'b0);
    // length lowered below current count
    write_window(16'd2);
    send_sample(16'sd1, 16'sd2, 16'sd3, 1'b0);
    write_window(16'd1);
    send_sample(-16'sd32768, 16'sd32767, 16'sd0, 1'b0);
    send_sample(16'sd32767, -16'sd32768, -16'sd1, 1'b0);
    write_window(16'd0);
    send_sample(16'sd1234, -16'sd4321, 16'sd0, 1'b0);
    write_window(16'd2);
    send_sample(16'sd9, 16'sd9, 16'sd9, 1'b0);
    send_sample(-16'sd9, 16'sd4, 16'sd2, 1'b1);
    send_sample(16'sd11, 16'sd5, -16'sd2, 1'b0);
    write_window(16'd4);
    for (int i = 0; i < 4; i++)
      send_sample(i[0] ? 16'sh7FFF : 16'sh8000, i[0] ? 16'sh8000 : 16'sh7FFF,
                  16'sh8000, 1'b0);
    // widest window register, then shrink
    write_window(16'hFFFF);
    for (int i = 0; i < 6; i++) send_sample(rand_axis(), rand_axis(), rand_axis(), 1'b0);
    write_window(16'd3);
    send_sample(rand_axis(), rand_axis(), rand_axis(), 1'b0);

    random_phase(80, 0, 0, 1'b1);
    random_phase(80, 59, 0, 1'b0);
    random_phase(80, 0, 59, 1'b0);
    random_phase(80, 30, 30, 1'b0);

    drain();
    $display("Run covered %0d samples and %0d axis results over window lengths 0 to 65535,",
             samples_sent, stats_seen);
    $display("with restarts, extreme samples, random idling and a long output hold-off.");
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
